// ----- src/cwt_pkg.sv -----
// cwt_pkg: shared types, constants and byte classification for the chunked word tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none
package cwt_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_IDX_W        = 2;
    localparam int QUEUE_DEPTH      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_STOP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_LEAD   = 2'd3;

    // One classified byte, handed from the front to the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       delim;
        logic       eof;
        logic       ge_stop;
        logic       gt_stop;
    } t_cls;

    // One result item
    typedef struct packed {
        logic [7:0] char_out;
        logic       has_char;
        logic       word_last;
        logic       stream_done;
    } t_res;

    // C-locale space or punctuation
    function automatic logic is_delim(input logic [7:0] b);
        logic r;
        r = ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20) ||
            ((b >= 8'h21) && (b <= 8'h2F)) ||
            ((b >= 8'h3A) && (b <= 8'h40)) ||
            ((b >= 8'h5B) && (b <= 8'h60)) ||
            ((b >= 8'h7B) && (b <= 8'h7E));
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/chunked_word_tokenizer.sv -----
// chunked_word_tokenizer: top level; joins front classifier, queue and back end.
// Depends on cwt_pkg, cwt_front, cwt_queue and cwt_back.
//
// Usage:
//  - Write file_length, chunk_start, chunk_stop and drop_leading_partial through
//    the plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is idle.
//  - Feed file bytes in order from chunk_start on the input channel
//    (i_valid / o_ready / i_data_byte); each transfer is one byte.
//  - Results leave on the output channel (o_valid / i_ready): word characters,
//    the first of each word lower-cased, the last one marked by o_word_last, and
//    o_stream_done on the result that closes the chunk (a bare marker has
//    o_has_char low). A character leaves only once the byte after it is seen.
//  - Throughput: one byte per cycle while the receiver takes every result. A
//    byte is written into the queue on its transfer; from the queue head its
//    result lands in the output register, from which it is offered.
//  - When the receiver stalls, the output register holds its result and the
//    two-entry queue absorbs bytes; o_ready drops only once the queue is full.
//  - After the stream is done, further bytes are taken and dropped.
//  - Reset (synchronous, active low) clears the registers other than the queue
//    storage to zero, empties the queue and returns the scan to its start mode.
`default_nettype none
module chunked_word_tokenizer
    import cwt_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output      logic                  o_ready,
    input  wire logic [7:0]            i_data_byte,
    output      logic                  o_valid,
    input  wire logic                  i_ready,
    output      logic [7:0]            o_char_out,
    output      logic                  o_has_char,
    output      logic                  o_word_last,
    output      logic                  o_stream_done
);

    t_cls cls_in;
    t_cls cls_head;
    logic accept;
    logic drop;
    logic q_valid;
    logic q_pop;

    // A byte transfers whenever the queue has room
    assign accept = i_valid && o_ready;

    cwt_front #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_cls       (cls_in),
        .o_drop      (drop)
    );

    cwt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_entry    (cls_in),
        .o_not_full (o_ready),
        .o_valid    (q_valid),
        .i_pop      (q_pop),
        .o_entry    (cls_head)
    );

    cwt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_drop        (drop),
        .i_q_valid     (q_valid),
        .i_cls         (cls_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_char_out    (o_char_out),
        .o_has_char    (o_has_char),
        .o_word_last   (o_word_last),
        .o_stream_done (o_stream_done)
    );

endmodule
`default_nettype wire

// ----- src/cwt_front.sv -----
// cwt_front: configuration registers, running offset and byte classification.
// Depends on cwt_pkg.
`default_nettype none
module cwt_front
    import cwt_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_data_byte,
    output      t_cls                  o_cls,
    output      logic                  o_drop
);

    logic [OFFSET_WIDTH-1:0] r_file_len;
    logic [OFFSET_WIDTH-1:0] r_start;
    logic [OFFSET_WIDTH-1:0] r_stop;
    logic                    r_drop;
    logic                    r_started;
    logic [OFFSET_WIDTH-1:0] r_pos;
    logic [OFFSET_WIDTH-1:0] pos_now;

    // The first item takes its offset straight from the chunk start
    assign pos_now = r_started ? r_pos : r_start;

    always_comb begin
        o_cls.data_byte = i_data_byte;
        o_cls.delim     = is_delim(i_data_byte);
        o_cls.eof       = (pos_now >= r_file_len);
        o_cls.ge_stop   = (pos_now >= r_stop);
        o_cls.gt_stop   = (pos_now > r_stop);
    end

    assign o_drop = r_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_len <= '0;
            r_start    <= '0;
            r_stop     <= '0;
            r_drop     <= 1'b0;
            r_started  <= 1'b0;
            r_pos      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FILE_LENGTH: r_file_len <= OFFSET_WIDTH'(i_cfg_data);
                    REG_CHUNK_START: r_start    <= OFFSET_WIDTH'(i_cfg_data);
                    REG_CHUNK_STOP:  r_stop     <= OFFSET_WIDTH'(i_cfg_data);
                    REG_DROP_LEAD:   r_drop     <= i_cfg_data[0];
                    default:         r_drop     <= r_drop;
                endcase
            end
            if (i_accept) begin
                r_started <= 1'b1;
                r_pos     <= pos_now + OFFSET_WIDTH'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/cwt_queue.sv -----
// cwt_queue: short register queue of classified bytes between front and back.
// Depends on cwt_pkg.
`default_nettype none
module cwt_queue
    import cwt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_entry,
    output      logic o_not_full,
    output      logic o_valid,
    input  wire logic i_pop,
    output      t_cls o_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cls             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_not_full = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_entry    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/cwt_back.sv -----
// cwt_back: scan-mode state machine and output register; turns classified bytes
// into word characters and end markers. Depends on cwt_pkg.
`default_nettype none
module cwt_back
    import cwt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_drop,
    input  wire logic       i_q_valid,
    input  wire t_cls       i_cls,
    output      logic       o_pop,
    output      logic       o_valid,
    input  wire logic       i_ready,
    output      logic [7:0] o_char_out,
    output      logic       o_has_char,
    output      logic       o_word_last,
    output      logic       o_stream_done
);

    typedef enum logic [2:0] {
        S_START,
        S_DROP,
        S_GAP,
        S_WORD,
        S_DONE
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic       r_out_valid;
    t_res       r_out, n_out;
    logic       emit;
    logic       out_free;
    t_mode      entry_mode;
    logic       to_gap;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_q_valid && out_free;

    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        n_out  = '0;
        emit   = 1'b0;
        to_gap = 1'b0;

        // Leave the start mode on the first byte
        if (r_mode == S_START) begin
            entry_mode = i_drop ? S_DROP : S_GAP;
        end else begin
            entry_mode = r_mode;
        end

        if (entry_mode == S_DROP) begin
            if (i_cls.eof || i_cls.ge_stop) begin
                emit                 = 1'b1;
                n_out.stream_done    = 1'b1;
                n_mode               = S_DONE;
            end else if (!i_cls.delim) begin
                n_mode = S_DROP;
            end else begin
                to_gap = 1'b1;
            end
        end

        if (entry_mode == S_GAP || to_gap) begin
            if (i_cls.eof || (i_cls.delim && i_cls.ge_stop) ||
                (!i_cls.delim && i_cls.gt_stop)) begin
                emit              = 1'b1;
                n_out.stream_done = 1'b1;
                n_mode            = S_DONE;
            end else if (i_cls.delim) begin
                n_mode = S_GAP;
            end else begin
                n_held = to_lower(i_cls.data_byte);
                n_mode = S_WORD;
            end
        end

        if (entry_mode == S_WORD) begin
            emit           = 1'b1;
            n_out.char_out = r_held;
            n_out.has_char = 1'b1;
            if (i_cls.eof || i_cls.delim) begin
                n_out.word_last   = 1'b1;
                n_out.stream_done = i_cls.eof || i_cls.ge_stop;
                n_mode            = (i_cls.eof || i_cls.ge_stop) ? S_DONE : S_GAP;
            end else begin
                n_held = i_cls.data_byte;
            end
        end

        // After the end every byte is dropped with no effect
        if (entry_mode == S_DONE) begin
            n_mode = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= S_START;
            r_held      <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (o_pop) begin
                r_mode <= n_mode;
                r_held <= n_held;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_char_out    = r_out.char_out;
    assign o_has_char    = r_out.has_char;
    assign o_word_last   = r_out.word_last;
    assign o_stream_done = r_out.stream_done;

endmodule
`default_nettype wire

// ----- sim/tb_chunked_word_tokenizer.sv -----
// Self-checking testbench for chunked_word_tokenizer: random valid/ready traffic on
// both channels, results checked against a built-in model of the tokeniser.
// Depends on cwt_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module tb_chunked_word_tokenizer;
    import cwt_pkg::*;

    // Scan states of the tokeniser model, in the block's own encoding
    typedef enum logic [2:0] {
        SCAN_START = 3'd0,
        SCAN_DROP  = 3'd1,
        SCAN_GAP   = 3'd2,
        SCAN_WORD  = 3'd3,
        SCAN_DONE  = 3'd4
    } t_scan;

    typedef enum int {
        END_AT_EOF,
        END_AT_STOP,
        END_STOP_CLEARED,
        END_LENGTH_CLEARED
    } t_ending;

    // Block ports; every input starts at a known value
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = REG_FILE_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [7:0]            o_char_out;
    logic                  o_has_char;
    logic                  o_word_last;
    logic                  o_stream_done;

    chunked_word_tokenizer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_char_out   (o_char_out),
        .o_has_char   (o_has_char),
        .o_word_last  (o_word_last),
        .o_stream_done(o_stream_done)
    );

    // Model copy of the configuration registers
    logic [31:0] file_len;
    logic [31:0] start_off;
    logic [31:0] stop_off;
    logic        drop_lead;

    // Model copy of the scan state
    logic [31:0] scan_pos;
    t_scan       scan_state;
    logic [7:0]  held_byte;

    logic [7:0]  bytes_to_send [$];  // file bytes still to be offered
    t_res        pending_tokens [$]; // token results predicted but not yet seen

    bit          calm;               // no idling on either side while set
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned errors;
    int unsigned bytes_sent;
    int unsigned results_seen;
    int unsigned settings_used;
    t_res        want;

    // ---------------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Generous ceiling on the whole run; a correct run needs a small fraction
    initial begin
        #(10_000_000);
        $display("Timeout: the block stopped making progress");
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Tokeniser model
    // ---------------------------------------------------------------------

    // Space or punctuation in the C locale; every other byte is part of a word
    function automatic bit is_separator(input logic [7:0] b);
        return (b >= 8'h09 && b <= 8'h0D) || (b >= 8'h20 && b <= 8'h2F) ||
               (b >= 8'h3A && b <= 8'h40) || (b >= 8'h5B && b <= 8'h60) ||
               (b >= 8'h7B && b <= 8'h7E);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
    endfunction

    function automatic void emit_token(input logic [7:0] c, input logic has,
                                       input logic last, input logic done);
        t_res r;
        r.char_out    = c;
        r.has_char    = has;
        r.word_last   = last;
        r.stream_done = done;
        pending_tokens.push_back(r);
    endfunction

    // Close the stream with a bare end marker
    function automatic void close_bare();
        scan_state = SCAN_DONE;
        emit_token(8'h00, 1'b0, 1'b0, 1'b1);
    endfunction

    // Advance the model by one transferred byte and queue the tokens it releases
    function automatic void tokenise_byte(input logic [7:0] b);
        logic [31:0] p;
        bit          at_eof;
        bit          sep;
        bit          done;

        if (scan_state == SCAN_DONE) return;
        if (scan_state == SCAN_START) begin
            scan_pos   = start_off;
            scan_state = drop_lead ? SCAN_DROP : SCAN_GAP;
        end
        p      = scan_pos;
        at_eof = (p >= file_len);
        sep    = is_separator(b);

        // Skip the tail of a word owned by the previous chunk
        if (scan_state == SCAN_DROP) begin
            if (at_eof || p >= stop_off) begin
                close_bare();
                return;
            end
            if (!sep) begin
                scan_pos++;
                return;
            end
            scan_state = SCAN_GAP;
        end

        if (scan_state == SCAN_GAP) begin
            if (at_eof) begin
                close_bare();
                return;
            end
            if (sep) begin
                if (p >= stop_off) close_bare();
                else scan_pos++;
                return;
            end
            // A word starting past the stop offset belongs to the next chunk
            if (p > stop_off) begin
                close_bare();
                return;
            end
            held_byte  = fold_case(b);
            scan_state = SCAN_WORD;
            scan_pos++;
            return;
        end

        // Inside a word: release the held character, marking it last if the word ends
        if (at_eof || sep) begin
            done = at_eof || (p >= stop_off);
            emit_token(held_byte, 1'b1, 1'b1, done);
            if (done) begin
                scan_state = SCAN_DONE;
            end else begin
                scan_state = SCAN_GAP;
                scan_pos++;
            end
            return;
        end
        emit_token(held_byte, 1'b1, 1'b0, 1'b0);
        held_byte = b;
        scan_pos++;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0]  b;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return 8'(8'h41 + $urandom_range(0, 25));
        if (r < 70) return 8'(8'h61 + $urandom_range(0, 25));
        if (r < 80) return 8'(8'h30 + $urandom_range(0, 9));
        // Any other word byte: controls, NUL, DEL, upper half
        do b = 8'($urandom_range(0, 255)); while (is_separator(b));
        return b;
    endfunction

    function automatic logic [7:0] separator_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (!is_separator(b));
        return b;
    endfunction

    // Queue roughly n bytes of words and separators, with a sprinkling of raw noise
    task automatic queue_words(input int unsigned n);
        int unsigned queued;
        int unsigned len;
        queued = 0;
        while (queued < n) begin
            if ($urandom_range(0, 99) < 12) begin
                len = $urandom_range(1, 4);
                repeat (len) bytes_to_send.push_back(8'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) bytes_to_send.push_back(word_byte());
                queued += len;
                len = $urandom_range(1, 3);
                repeat (len) bytes_to_send.push_back(separator_byte());
            end
            queued += len;
        end
    endtask

    // Write one register through the configuration port and update its model copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_FILE_LENGTH: file_len = val;
            REG_CHUNK_START: begin
                start_off = val;
                if (scan_state == SCAN_START) scan_pos = val;
            end
            REG_CHUNK_STOP:  stop_off = val;
            REG_DROP_LEAD:   drop_lead = val[0];
            default: ;
        endcase
    endtask

    // Hold until every byte is transferred and every token has arrived, then let
    // the pipeline empty of bytes that release nothing
    task automatic wait_idle();
        do @(negedge i_clk);
        while (bytes_to_send.size() != 0 || i_valid || pending_tokens.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Driver: offer queued bytes, hold each until its transfer, idle at random
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                tokenise_byte(i_data_byte);
                bytes_sent++;
            end
            // Only a free slot may change; a byte on offer stays until taken
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    i_valid     <= 1'b1;
                    i_data_byte <= bytes_to_send.pop_front();
                    send_gap    = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: check each token transfer against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (pending_tokens.size() == 0) begin
                    $error("token transfer with nothing predicted: char_out %h has_char %b",
                           o_char_out, o_has_char);
                    errors++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (o_char_out !== want.char_out) begin
                        $error("char_out: expected %h, got %h", want.char_out, o_char_out);
                        errors++;
                    end
                    if (o_has_char !== want.has_char) begin
                        $error("has_char: expected %b, got %b", want.has_char, o_has_char);
                        errors++;
                    end
                    if (o_word_last !== want.word_last) begin
                        $error("word_last: expected %b, got %b", want.word_last, o_word_last);
                        errors++;
                    end
                    if (o_stream_done !== want.stream_done) begin
                        $error("stream_done: expected %b, got %b",
                               want.stream_done, o_stream_done);
                        errors++;
                    end
                end
            end
            // Stall the receiver at random, independently of the sender
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready    <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: reset, configure, run the phases, close the stream, report
    // ---------------------------------------------------------------------
    initial begin
        t_ending     ending;
        string       ending_name;
        int unsigned waited;

        file_len       = '0;
        start_off      = '0;
        stop_off       = '0;
        drop_lead      = 1'b0;
        scan_pos       = '0;
        scan_state     = SCAN_START;
        held_byte      = 8'h00;
        calm           = 1'b0;
        errors         = 0;
        bytes_sent     = 0;
        results_seen   = 0;
        settings_used  = 1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Open the whole file; chunk_start goes through its top value first, which
        // only moves the start point while nothing has been read
        write_reg(REG_FILE_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_CHUNK_STOP, 32'hFFFF_FFFF);
        write_reg(REG_CHUNK_START, 32'hFFFF_FFFF);
        write_reg(REG_CHUNK_START,
                  ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(1, 32'hF000_0000));
        // Only bit 0 counts; junk in the upper bits must be ignored
        write_reg(REG_DROP_LEAD, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1});

        // Directed opening: a dropped partial word, then case folding at both ends of
        // the alphabet, single-character words, non-ASCII word bytes and every
        // boundary byte of the separator classes
        @(negedge i_clk);
        bytes_to_send = '{8'h78, 8'h59, 8'h20,
                          8'h41, 8'h62, 8'h2F,
                          8'h5A, 8'h09,
                          8'h00, 8'hFF, 8'h7F, 8'h3A,
                          8'h0D, 8'h7E, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h21,
                          8'h30, 8'h39, 8'h5B,
                          8'h61, 8'h80, 8'h0E, 8'h20};
        wait_idle();

        // Random phases; the sender pauses at each boundary until every token is in
        for (int ph = 0; ph < 5; ph++) begin
            calm = (ph == 2);
            settings_used++;
            write_reg(REG_FILE_LENGTH, (ph % 2 == 0) ? 32'hFFFF_FFFF
                                     : scan_pos + $urandom_range(4096, 1 << 20));
            write_reg(REG_CHUNK_STOP, (ph % 2 == 1) ? 32'hFFFF_FFFF
                                    : scan_pos + $urandom_range(4096, 1 << 20));
            // Neither has any effect once the scan is under way
            write_reg(REG_DROP_LEAD, $urandom);
            write_reg(REG_CHUNK_START, $urandom);
            @(negedge i_clk);
            queue_words(95);
            wait_idle();
        end

        // Close the stream one of four ways, chosen by the seed
        calm = 1'b0;
        settings_used++;
        ending = t_ending'($urandom_range(0, 3));
        case (ending)
            END_AT_EOF: begin
                ending_name = "end of file";
                write_reg(REG_FILE_LENGTH, scan_pos + $urandom_range(0, 20));
            end
            END_AT_STOP: begin
                ending_name = "the stop offset";
                write_reg(REG_CHUNK_STOP, scan_pos + $urandom_range(0, 20));
            end
            END_STOP_CLEARED: begin
                ending_name = "a stop offset of zero";
                write_reg(REG_CHUNK_STOP, 32'h0);
            end
            default: begin
                ending_name = "a file length of zero";
                write_reg(REG_FILE_LENGTH, 32'h0);
            end
        endcase
        @(negedge i_clk);
        queue_words(40);
        // Bytes after the end are taken and must release nothing
        repeat (12) bytes_to_send.push_back(8'($urandom_range(0, 255)));

        do @(negedge i_clk); while (bytes_to_send.size() != 0 || i_valid);
        waited = 0;
        while (pending_tokens.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (10) @(negedge i_clk);
        if (pending_tokens.size() != 0) begin
            $error("%0d predicted tokens never arrived", pending_tokens.size());
            errors++;
        end

        $display("Sent %0d file bytes and checked %0d token transfers over %0d settings.",
                 bytes_sent, results_seen, settings_used);
        $display("The stream was closed by %s.", ending_name);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
